FILE: hw/rtl/lrsumv_pkg.sv
package lrsumv_pkg;

    // Field and storage widths.
    localparam int VAL_W = 16;
    localparam int SUF_W = 40;
    localparam int ROW_W = 48;

    // Parameter defaults.
    localparam int RANK_DEF = 16;
    localparam int FRAC_DEF = 12;

    typedef struct packed {
        logic signed [VAL_W-1:0] u_value;
        logic signed [VAL_W-1:0] v_value;
        logic signed [VAL_W-1:0] d_value;
        logic signed [VAL_W-1:0] x_value;
        logic                    first_row;
        logic                    last_in_row;
    } t_in_item;

    typedef struct packed {
        logic signed [ROW_W-1:0] row_result;
        logic                    saturated;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } t_sts;

endpackage

FILE: hw/rtl/lrsumv_dpath.sv
module lrsumv_dpath #(
    parameter int RANK = lrsumv_pkg::RANK_DEF,
    parameter int FRAC = lrsumv_pkg::FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrsumv_pkg::t_cmd      i_cmd,
    input  lrsumv_pkg::t_in_item  i_in_item,
    output lrsumv_pkg::t_sts      o_sts,
    output lrsumv_pkg::t_out_item o_out_item
);
    import lrsumv_pkg::*;

    localparam int IDX_W = (RANK > 1) ? $clog2(RANK) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RANK - 1);

    localparam int DV_W   = 2 * VAL_W;          // d*v
    localparam int DVX_W  = 3 * VAL_W;          // d*v*x
    localparam int US_W   = VAL_W + SUF_W;      // u*s
    localparam int USR_W  = US_W + 1;           // u*s plus rounding carry
    localparam int DVXR_W = DVX_W + 1;
    localparam int ASUM_W = USR_W + 1;
    localparam int SSUM_W = DVXR_W + 1;

    // Half an output LSB; zero when there are no fraction bits.
    localparam logic signed [USR_W-1:0]  US_RND  = (USR_W'(1) << FRAC) >> 1;
    localparam logic signed [DVXR_W-1:0] DVX_RND = (DVXR_W'(1) << (2 * FRAC)) >> 1;

    localparam logic signed [ROW_W-1:0] ACC_MAX = {1'b0, {(ROW_W-1){1'b1}}};
    localparam logic signed [ROW_W-1:0] ACC_MIN = {1'b1, {(ROW_W-1){1'b0}}};
    localparam logic signed [SUF_W-1:0] SUF_MAX = {1'b0, {(SUF_W-1){1'b1}}};
    localparam logic signed [SUF_W-1:0] SUF_MIN = {1'b1, {(SUF_W-1){1'b0}}};

    logic signed [SUF_W-1:0] r_mem [RANK];

    logic [IDX_W-1:0]        r_idx;
    logic                    r_in_first;
    logic                    r_clip;
    logic signed [ROW_W-1:0] r_acc;

    logic signed [SUF_W-1:0] r_rd;
    logic signed [VAL_W-1:0] r_u;
    logic signed [VAL_W-1:0] r_x;
    logic signed [DV_W-1:0]  r_dv;
    logic                    r_last;
    logic signed [SUF_W-1:0] r_s;
    logic signed [US_W-1:0]  r_us;
    logic signed [DVX_W-1:0] r_dvx;
    t_out_item               r_out;

    logic signed [SUF_W-1:0]  w_s;
    logic signed [USR_W-1:0]  w_us_rnd;
    logic signed [USR_W-1:0]  w_us_term;
    logic signed [ASUM_W-1:0] w_acc_sum;
    logic                     w_acc_ovf;
    logic signed [ROW_W-1:0]  w_acc_new;
    logic signed [DVXR_W-1:0] w_dvx_rnd;
    logic signed [DVXR_W-1:0] w_dvx_term;
    logic signed [SSUM_W-1:0] w_suf_sum;
    logic                     w_suf_ovf;
    logic signed [SUF_W-1:0]  w_suf_new;
    logic                     w_clip_any;
    logic [IDX_W-1:0]         w_idx_next;

    // The first row reads the suffix sums as zero.
    assign w_s = r_in_first ? '0 : r_rd;

    always_comb begin
        w_us_rnd   = USR_W'(r_us) + US_RND;
        w_us_term  = w_us_rnd >>> FRAC;
        w_acc_sum  = ASUM_W'(r_acc) + ASUM_W'(w_us_term);
        w_acc_ovf  = (w_acc_sum[ASUM_W-1:ROW_W-1] != {(ASUM_W-ROW_W+1){w_acc_sum[ASUM_W-1]}});
        if (w_acc_ovf) begin
            w_acc_new = w_acc_sum[ASUM_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc_new = w_acc_sum[ROW_W-1:0];
        end

        w_dvx_rnd  = DVXR_W'(r_dvx) + DVX_RND;
        w_dvx_term = w_dvx_rnd >>> (2 * FRAC);
        w_suf_sum  = SSUM_W'(r_s) + SSUM_W'(w_dvx_term);
        w_suf_ovf  = (w_suf_sum[SSUM_W-1:SUF_W-1] != {(SSUM_W-SUF_W+1){w_suf_sum[SSUM_W-1]}});
        if (w_suf_ovf) begin
            w_suf_new = w_suf_sum[SSUM_W-1] ? SUF_MIN : SUF_MAX;
        end else begin
            w_suf_new = w_suf_sum[SUF_W-1:0];
        end

        w_clip_any = r_clip | w_acc_ovf | w_suf_ovf;
        w_idx_next = (r_idx == IDX_LAST) ? '0 : r_idx + IDX_W'(1);
    end

    // Suffix sum memory: one read at item load, one write at commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_mem[r_idx];
        end
        if (i_cmd.commit) begin
            r_mem[r_idx] <= w_suf_new;
        end
    end

    // Payload pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u    <= i_in_item.u_value;
            r_x    <= i_in_item.x_value;
            r_last <= i_in_item.last_in_row;
            r_dv   <= i_in_item.d_value * i_in_item.v_value;
        end
        if (i_cmd.mul) begin
            r_s   <= w_s;
            r_us  <= r_u * w_s;
            r_dvx <= r_dv * r_x;
        end
        if (i_cmd.commit && r_last) begin
            r_out.row_result <= w_acc_new;
            r_out.saturated  <= w_clip_any;
        end
    end

    // Row state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_in_first <= 1'b0;
            r_clip     <= 1'b0;
            r_acc      <= '0;
        end else begin
            if (i_cmd.load && (r_idx == '0)) begin
                r_in_first <= i_in_item.first_row;
            end
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_acc  <= w_acc_new;
                    r_clip <= w_clip_any;
                    r_idx  <= w_idx_next;
                end
            end
        end
    end

    assign o_sts.last = r_last;
    assign o_out_item = r_out;

endmodule

FILE: hw/rtl/lrsumv_ctrl.sv
module lrsumv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  lrsumv_pkg::t_sts i_sts,
    output lrsumv_pkg::t_cmd o_cmd
);
    import lrsumv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd.load   = i_in_valid && r_in_ready;
        o_cmd.mul    = (r_state == ST_MUL);
        // A row end waits until the result register is free.
        o_cmd.commit = (r_state == ST_ACC) &&
                       (!i_sts.last || !r_out_valid || i_out_ready);

        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state    = ST_MUL;
                    n_in_ready = 1'b0;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (o_cmd.commit) begin
                    n_state    = ST_IDLE;
                    n_in_ready = 1'b1;
                    if (i_sts.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: begin
                n_state    = ST_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready && (r_state == ST_MUL))
        else $error("item accepted while another is in flight");

    a_result_follows_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit && i_sts.last |=> o_out_valid)
        else $error("row end did not raise a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit && i_sts.last |-> !o_out_valid || i_out_ready)
        else $error("result register overwritten while full");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("ready raised outside idle");

endmodule

FILE: hw/rtl/low_rank_strict_upper_matvec_core.sv
// Strictly upper-triangular low-rank matrix-vector product engine.
//
// Each input item carries one rank element of one row: u, v, d, the row's
// x entry, a first-row flag and a last-element flag. Rows are fed from the
// last matrix row to the first. For every item the engine adds u*s to the
// row's dot accumulator and adds d*v*x to the stored suffix sum s of that
// rank position. On the last element of a row one result item leaves on the
// output channel: the row's z value, saturated to 48 bits, and a flag that
// tells whether any add of that row clipped. Results appear in reverse row
// order. Both channels use a valid/ready handshake.
//
// Each item passes the stages accept (suffix sum read and d*v), multiply
// (u*s and d*v*x), accumulate and suffix write-back. A suffix entry's
// read-modify-write spans those stages, so the next item is accepted only
// after that write-back. A result becomes valid the cycle after the third
// stage of the row's last item. Results sit in an output register, so a
// stalled receiver blocks only the next row end, which waits in its last
// stage until the register is free. Reset clears the row state and the
// channels; suffix sums hold nothing until the first row writes them.
module low_rank_strict_upper_matvec_core #(
    parameter int RANK = lrsumv_pkg::RANK_DEF,
    parameter int FRAC = lrsumv_pkg::FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lrsumv_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lrsumv_pkg::t_out_item o_out_item
);
    import lrsumv_pkg::*;

    // Commands and status between controller and datapath.
    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences each item through its three stages and owns
    // both handshakes.
    lrsumv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the suffix sum memory, the multipliers, the
    // accumulator and the result register.
    lrsumv_dpath #(
        .RANK (RANK),
        .FRAC (FRAC)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_sts      (w_sts),
        .o_out_item (o_out_item)
    );

endmodule

FILE: verif/low_rank_strict_upper_matvec_core_tb.sv
module low_rank_strict_upper_matvec_core_tb;

    import lrsumv_pkg::*;

    // The design is built with its default sizes, so the checker uses the same.
    localparam int RANK = RANK_DEF;
    localparam int FRAC = FRAC_DEF;

    // Saturation limits of the suffix sums and of the row accumulator.
    localparam longint SFX_MAX = (longint'(1) <<< (SUF_W - 1)) - 1;
    localparam longint SFX_MIN = -(longint'(1) <<< (SUF_W - 1));
    localparam longint ACC_MAX = (longint'(1) <<< (ROW_W - 1)) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< (ROW_W - 1));

    // Random items after the directed rows, and the settle time at the end.
    localparam int RAND_ITEMS   = 650;
    localparam int DRAIN_CYCLES = 20;

    localparam logic signed [VAL_W-1:0] VMAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VMIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VONE = 16'sd1;
    localparam logic signed [VAL_W-1:0] VNEG = -16'sd1;
    localparam logic signed [VAL_W-1:0] VZRO = 16'sd0;
    localparam logic signed [ROW_W-1:0] ZROW = 48'sd0;

    // One row of the directed table. Where "typed" is set, the row result is
    // given by hand; every other item is checked against the predictor.
    typedef struct packed {
        logic signed [VAL_W-1:0] u;
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W-1:0] d;
        logic signed [VAL_W-1:0] x;
        logic                    first;
        logic                    last;
        logic                    typed;
        logic signed [ROW_W-1:0] row;
        logic                    sat;
    } t_dir_row;

    localparam int DIR_N = 24;

    // Directed stimulus.
    // Rows 0..16: a first row of RANK+1 elements. It writes every suffix entry,
    // so no later row can read one that was never written. The row wraps back
    // to rank position 0 on its last element, where the first-row flag is
    // sampled again; it is set there, so the whole row reads zero suffix sums
    // and the result must be zero. The flag on element 4 is ignored.
    // Row 17: a single-element row with extreme operands.
    // Rows 18..20: a short row with the first-row flag set on a middle element,
    // which must have no effect.
    // Row 21: a fresh first row of one element; only entry 0 restarts.
    // Rows 22..23: reads the restarted entry 0 and the older entry 1.
    t_dir_row dir_rows [DIR_N] = '{
        '{VMAX, VMAX, VMAX, VMIN, 1'b1, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMIN, VMIN, VMIN, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMIN, VMAX, VMIN, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMAX, VMIN, VMAX, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VZRO, VZRO, VZRO, VMIN, 1'b1, 1'b0, 1'b0, ZROW, 1'b0},
        '{VONE, VONE, VONE, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VNEG, VNEG, VNEG, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMAX, VMIN, VMIN, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'sh1234, 16'sh5A5A, 16'shA5A5, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'shC3C3, 16'sh0F0F, 16'shF0F0, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'sh5555, 16'shAAAA, 16'sh3333, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'shCCCC, 16'sh6666, 16'sh9999, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'sh0100, 16'sh7000, 16'sh8001, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'shFF00, 16'sh00FF, 16'sh7FFE, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'sh4000, 16'shC000, 16'sh2000, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{16'sh8001, 16'sh7FFE, 16'shE000, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMAX, VMAX, VMIN, VMIN, 1'b1, 1'b1, 1'b1, ZROW, 1'b0},
        '{VMAX, VMIN, VMAX, VMAX, 1'b0, 1'b1, 1'b0, ZROW, 1'b0},
        '{VMIN, VMAX, VMIN, VMIN, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMIN, VMIN, VMIN, VMIN, 1'b1, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMAX, VONE, VNEG, VMIN, 1'b0, 1'b1, 1'b0, ZROW, 1'b0},
        '{VMAX, VMAX, VMIN, VMAX, 1'b1, 1'b1, 1'b1, ZROW, 1'b0},
        '{VMIN, VNEG, VONE, VONE, 1'b0, 1'b0, 1'b0, ZROW, 1'b0},
        '{VMAX, VMAX, VMAX, VONE, 1'b0, 1'b1, 1'b0, ZROW, 1'b0}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Predictor state: its own copy of the suffix sums and the row registers.
    longint      suffix_sum [RANK];
    int unsigned rank_pos;
    longint      row_acc;
    logic        row_is_first;
    logic        row_clipped;

    // Row results that the design still owes, oldest first.
    t_out_item   z_expected [$];
    t_out_item   z_want;
    int          mismatch_cnt;
    int          burst_left;

    low_rank_strict_upper_matvec_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Rounds off the low sh fraction bits: add half an LSB, then an arithmetic
    // shift, which floors.
    function automatic longint round_shr(input longint value, input int sh);
        if (sh == 0) begin
            return value;
        end
        return (value + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Clamps to a range and remembers for the row that it clipped.
    function automatic longint clamp(input longint value, input longint lo,
                                     input longint hi);
        if (value > hi) begin
            row_clipped = 1'b1;
            return hi;
        end
        if (value < lo) begin
            row_clipped = 1'b1;
            return lo;
        end
        return value;
    endfunction

    // Applies one accepted item to the predictor. Returns 1 and the row's z
    // value when the item closes a row.
    function automatic bit matvec_step(input t_in_item it, output t_out_item z);
        longint u;
        longint v;
        longint d;
        longint x;
        longint s;
        longint term;
        u = it.u_value;
        v = it.v_value;
        d = it.d_value;
        x = it.x_value;
        z = '0;
        // The first-row flag counts only at rank position 0, including a
        // wrap back to position 0 within an overlong row.
        if (rank_pos == 0) begin
            row_is_first = it.first_row;
        end
        s = row_is_first ? 64'sd0 : suffix_sum[rank_pos];
        term = round_shr(u * s, FRAC);
        row_acc = clamp(row_acc + term, ACC_MIN, ACC_MAX);
        term = round_shr(d * v * x, 2 * FRAC);
        suffix_sum[rank_pos] = clamp(s + term, SFX_MIN, SFX_MAX);
        rank_pos = (rank_pos + 1) % RANK;
        if (!it.last_in_row) begin
            return 1'b0;
        end
        z.row_result = row_acc[ROW_W-1:0];
        z.saturated  = row_clipped;
        row_acc      = 0;
        row_clipped  = 1'b0;
        rank_pos     = 0;
        return 1'b1;
    endfunction

    // Mostly full-range values, with the extremes and small magnitudes
    // around zero drawn often.
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] r;
        r = VAL_W'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                r = VMAX;
            end
            1: begin
                r = VMIN;
            end
            2: begin
                r = {{(VAL_W-6){r[5]}}, r[5:0]};
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Offers one item and holds it until accepted. The caller is always just
    // past a rising edge. After acceptance the sender either goes straight on
    // with the next item, keeping valid high, or ends its burst with a gap.
    // An expectation given by hand replaces the predicted one; the predictor
    // still consumes the item so its state stays in step.
    task automatic offer(input t_in_item it, input bit typed, input t_out_item typed_z);
        t_out_item z;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (matvec_step(it, z)) begin
            z_expected.push_back(typed ? typed_z : z);
        end
        if (burst_left == 0) begin
            // Now and then a long burst keeps the input busy back to back.
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Sender: reset, the directed table, then random rows.
    initial begin
        t_in_item                it;
        t_out_item               typed_z;
        logic signed [VAL_W-1:0] row_x;
        logic                    row_first;
        int                      row_len;
        int                      sent;
        mismatch_cnt = 0;
        burst_left   = 0;
        rank_pos     = 0;
        row_acc      = 0;
        row_is_first = 1'b0;
        row_clipped  = 1'b0;
        for (int k = 0; k < RANK; k++) begin
            suffix_sum[k] = 0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            it.u_value          = dir_rows[k].u;
            it.v_value          = dir_rows[k].v;
            it.d_value          = dir_rows[k].d;
            it.x_value          = dir_rows[k].x;
            it.first_row        = dir_rows[k].first;
            it.last_in_row      = dir_rows[k].last;
            typed_z.row_result  = dir_rows[k].row;
            typed_z.saturated   = dir_rows[k].sat;
            offer(it, dir_rows[k].typed, typed_z);
        end

        // Random rows. Most are well formed with lengths up to RANK; some
        // are single elements and some run past RANK so the rank position
        // wraps. A few start over as a first row. The first-row flag on
        // later elements is noise the design must ignore, except where a
        // long row wraps to position 0. Rarely x changes within a row.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    row_len = 1;
                end
                1: begin
                    row_len = RANK;
                end
                2: begin
                    row_len = $urandom_range(RANK + 1, 2 * RANK + 2);
                end
                default: begin
                    row_len = $urandom_range(2, RANK - 1);
                end
            endcase
            row_x     = pick_value();
            row_first = ($urandom_range(0, 7) == 0);
            for (int e = 0; e < row_len; e++) begin
                it.u_value     = pick_value();
                it.v_value     = pick_value();
                it.d_value     = pick_value();
                it.x_value     = ($urandom_range(0, 15) == 0) ? pick_value() : row_x;
                it.first_row   = (e == 0) ? row_first : ($urandom_range(0, 3) == 0);
                it.last_in_row = (e == row_len - 1);
                offer(it, 1'b0, '0);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        // Wait for every owed result, then a little longer so that a stray
        // extra result would still be caught.
        while (z_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: alternates stretches of steady acceptance, random stalls and
    // long hold-offs. During a hold-off the sender keeps offering, so the
    // output register and the pipeline fill and the input must stall.
    initial begin
        int seg;
        int n;
        seg = 0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            seg++;
            if (seg % 9 == 4) begin
                n = $urandom_range(150, 300);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (seg % 2 == 0) begin
                n = $urandom_range(10, 60);
                repeat (n) begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                    @(posedge i_clk);
                end
            end else begin
                n = $urandom_range(10, 60);
                i_out_ready <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Result checker: each accepted result is compared with the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (z_expected.size() == 0) begin
                $error("unexpected result: row_result %0d, saturated %0b",
                       o_out_item.row_result, o_out_item.saturated);
                mismatch_cnt++;
            end else begin
                z_want = z_expected.pop_front();
                if (o_out_item.row_result !== z_want.row_result) begin
                    $error("row_result mismatch: expected %0d, actual %0d",
                           z_want.row_result, o_out_item.row_result);
                    mismatch_cnt++;
                end
                if (o_out_item.saturated !== z_want.saturated) begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           z_want.saturated, o_out_item.saturated);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, even with every gap and hold-off.
    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lrsumv_pkg.sv
hw/rtl/lrsumv_dpath.sv
hw/rtl/lrsumv_ctrl.sv
hw/rtl/low_rank_strict_upper_matvec_core.sv
verif/low_rank_strict_upper_matvec_core_tb.sv
